### hdl/acpb_pkg.sv
// shared types and constants for the anti-aliased circle pixel blender
// no dependencies; imported by every module of the block
`default_nettype none

package acpb_pkg;

    // wide enough for subsample grids up to 11 by 11 (121 subsamples)
    localparam int CNT_W = 7;

    // register stages in each half of the pipeline
    localparam int COV_STAGES   = 5;
    localparam int BLEND_STAGES = 5;

    localparam logic [7:0] CHAN_MAX = 8'd255;

    typedef enum logic [1:0] {
        REG_CENTER_X     = 2'd0,
        REG_CENTER_Y     = 2'd1,
        REG_RADIUS       = 2'd2,
        REG_SOURCE_COLOR = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
        logic [31:0] dest_pixel;
    } pixel_req_t;

    typedef struct packed {
        logic [31:0] new_pixel;
        logic        write_enable;
        logic [4:0]  coverage_count;
    } pixel_res_t;

    typedef struct packed {
        logic signed [13:0] center_x;
        logic signed [13:0] center_y;
        logic [11:0]        radius;
    } circle_cfg_t;

    typedef struct packed {
        logic             valid;
        logic [31:0]      dest_pixel;
        logic [CNT_W-1:0] count;
    } cov_bus_t;

endpackage

`default_nettype wire

### hdl/acpb_coverage.sv
// subsample coverage pipeline: five stages from pixel request to covered count
// depends on acpb_pkg
`default_nettype none

module acpb_coverage #(
    parameter int SUBSAMPLE_RADIUS = 2
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  valid,
    input  wire acpb_pkg::pixel_req_t  req,
    input  wire acpb_pkg::circle_cfg_t circle,
    output acpb_pkg::cov_bus_t         cov
);
    import acpb_pkg::*;

    localparam int GRID  = 2 * SUBSAMPLE_RADIUS + 1;
    localparam int BX_W  = 16 + $clog2(SUBSAMPLE_RADIUS + 1);
    localparam int RR_W  = 12 + $clog2(SUBSAMPLE_RADIUS + 1);
    localparam int SQ_W  = 2 * BX_W;
    localparam int SW    = SQ_W + 2;
    localparam int SUM_W = SQ_W + 1;
    localparam int ROW_W = $clog2(GRID + 1);
    localparam logic signed [BX_W-1:0] SCALE = BX_W'(SUBSAMPLE_RADIUS);

    // stage 1: scaled offsets from the centre
    logic                   v1_reg, v1_next;
    logic signed [BX_W-1:0] bx1_reg, bx1_next, by1_reg, by1_next;
    logic [RR_W-1:0]        rr1_reg, rr1_next;
    logic [31:0]            dest1_reg, dest1_next;
    // stage 2: squares
    logic                   v2_reg, v2_next;
    logic signed [BX_W-1:0] bx2_reg, bx2_next, by2_reg, by2_next;
    logic [SQ_W-1:0]        sqx2_reg, sqx2_next, sqy2_reg, sqy2_next;
    logic [2*RR_W-1:0]      lim2_reg, lim2_next;
    logic [31:0]            dest2_reg, dest2_next;
    // stage 3: per column and per row squared distances
    logic                   v3_reg, v3_next;
    logic [SQ_W-1:0]        sx3_reg [GRID];
    logic [SQ_W-1:0]        sx3_next [GRID];
    logic [SQ_W-1:0]        sy3_reg [GRID];
    logic [SQ_W-1:0]        sy3_next [GRID];
    logic [2*RR_W-1:0]      lim3_reg, lim3_next;
    logic [31:0]            dest3_reg, dest3_next;
    // stage 4: covered subsamples per row
    logic                   v4_reg, v4_next;
    logic [ROW_W-1:0]       row4_reg [GRID];
    logic [ROW_W-1:0]       row4_next [GRID];
    logic [31:0]            dest4_reg, dest4_next;
    // stage 5: total count
    logic                   v5_reg, v5_next;
    logic [CNT_W-1:0]       cnt5_reg, cnt5_next;
    logic [31:0]            dest5_reg, dest5_next;

    logic signed [BX_W-1:0]   dx, dy;
    logic signed [2*BX_W-1:0] px2, py2;
    logic signed [SW-1:0]     accx, accy;
    logic [SUM_W-1:0]         dsq;

    always_comb
    begin
        dx = BX_W'($signed({1'b0, req.pixel_x})) - BX_W'($signed(circle.center_x));
        dy = BX_W'($signed({1'b0, req.pixel_y})) - BX_W'($signed(circle.center_y));
        v1_next    = valid;
        bx1_next   = dx * SCALE;
        by1_next   = dy * SCALE;
        rr1_next   = RR_W'(circle.radius) * RR_W'(SUBSAMPLE_RADIUS);
        dest1_next = req.dest_pixel;
    end

    always_comb
    begin
        px2 = bx1_reg * bx1_reg;
        py2 = by1_reg * by1_reg;
        v2_next    = v1_reg;
        bx2_next   = bx1_reg;
        by2_next   = by1_reg;
        sqx2_next  = SQ_W'($unsigned(px2));
        sqy2_next  = SQ_W'($unsigned(py2));
        lim2_next  = rr1_reg * rr1_reg;
        dest2_next = dest1_reg;
    end

    // (b + a)^2 = b^2 + 2ab + a^2 with small constant a per column or row
    always_comb
    begin
        accx = '0;
        accy = '0;
        for (int i = 0; i < GRID; i++)
        begin
            accx = $signed({2'b00, sqx2_reg})
                 + SW'(bx2_reg) * SW'(2 * (i - SUBSAMPLE_RADIUS))
                 + SW'((i - SUBSAMPLE_RADIUS) * (i - SUBSAMPLE_RADIUS));
            accy = $signed({2'b00, sqy2_reg})
                 + SW'(by2_reg) * SW'(2 * (i - SUBSAMPLE_RADIUS))
                 + SW'((i - SUBSAMPLE_RADIUS) * (i - SUBSAMPLE_RADIUS));
            sx3_next[i] = accx[SQ_W-1:0];
            sy3_next[i] = accy[SQ_W-1:0];
        end
        v3_next    = v2_reg;
        lim3_next  = lim2_reg;
        dest3_next = dest2_reg;
    end

    always_comb
    begin
        dsq = '0;
        for (int j = 0; j < GRID; j++)
        begin
            row4_next[j] = '0;
            for (int i = 0; i < GRID; i++)
            begin
                dsq = {1'b0, sx3_reg[i]} + {1'b0, sy3_reg[j]};
                row4_next[j] = row4_next[j] + ROW_W'(dsq <= SUM_W'(lim3_reg));
            end
        end
        v4_next    = v3_reg;
        dest4_next = dest3_reg;
    end

    always_comb
    begin
        cnt5_next = '0;
        for (int j = 0; j < GRID; j++)
        begin
            cnt5_next = cnt5_next + CNT_W'(row4_reg[j]);
        end
        v5_next    = v4_reg;
        dest5_next = dest4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
            v5_reg <= v5_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bx1_reg   <= bx1_next;
        by1_reg   <= by1_next;
        rr1_reg   <= rr1_next;
        dest1_reg <= dest1_next;
        bx2_reg   <= bx2_next;
        by2_reg   <= by2_next;
        sqx2_reg  <= sqx2_next;
        sqy2_reg  <= sqy2_next;
        lim2_reg  <= lim2_next;
        dest2_reg <= dest2_next;
        sx3_reg   <= sx3_next;
        sy3_reg   <= sy3_next;
        lim3_reg  <= lim3_next;
        dest3_reg <= dest3_next;
        row4_reg  <= row4_next;
        dest4_reg <= dest4_next;
        cnt5_reg  <= cnt5_next;
        dest5_reg <= dest5_next;
    end

    assign cov.valid      = v5_reg;
    assign cov.dest_pixel = dest5_reg;
    assign cov.count      = cnt5_reg;

endmodule

`default_nettype wire

### hdl/acpb_blend.sv
// alpha scaling and colour blend pipeline: five stages from count to result
// depends on acpb_pkg
`default_nettype none

module acpb_blend #(
    parameter int SUBSAMPLE_RADIUS = 2
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire acpb_pkg::cov_bus_t  cov,
    input  wire logic [31:0]         source_color,
    output logic                     done,
    output acpb_pkg::pixel_res_t     result
);
    import acpb_pkg::*;

    localparam int GRID     = 2 * SUBSAMPLE_RADIUS + 1;
    localparam int D2       = GRID * GRID;
    localparam int N_W      = CNT_W + 8;
    localparam int FRAC     = 16;
    localparam int RECIP_W  = FRAC;
    localparam int RECIP_I  = (1 << FRAC) / D2;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_I);
    localparam logic [N_W-1:0]     D2_C  = N_W'(D2);

    // stage 1: count times alpha
    logic             v1_reg, v1_next;
    logic [N_W-1:0]   n1_reg, n1_next;
    logic [CNT_W-1:0] cnt1_reg, cnt1_next;
    logic [31:0]      dest1_reg, dest1_next;
    // stage 2: reciprocal estimate of the quotient
    logic             v2_reg, v2_next;
    logic [N_W-1:0]   n2_reg, n2_next;
    logic [7:0]       q2_reg, q2_next;
    logic [CNT_W-1:0] cnt2_reg, cnt2_next;
    logic [31:0]      dest2_reg, dest2_next;
    // stage 3: corrected scaled alpha
    logic             v3_reg, v3_next;
    logic [7:0]       a3_reg, a3_next;
    logic [CNT_W-1:0] cnt3_reg, cnt3_next;
    logic [31:0]      dest3_reg, dest3_next;
    // stage 4: weighted channel sums
    logic             v4_reg, v4_next;
    logic [15:0]      x4_reg [3];
    logic [15:0]      x4_next [3];
    logic [CNT_W-1:0] cnt4_reg, cnt4_next;
    logic [7:0]       alpha4_reg, alpha4_next;
    // stage 5: divide by 255 and pack
    logic             done_reg, done_next;
    pixel_res_t       res_reg, res_next;

    logic [N_W+RECIP_W-1:0] prod;
    logic [N_W-1:0]         rem;
    logic [16:0]            quo;
    logic [7:0]             chan [3];

    always_comb
    begin
        v1_next    = cov.valid;
        n1_next    = N_W'(cov.count) * N_W'(source_color[31:24]);
        cnt1_next  = cov.count;
        dest1_next = cov.dest_pixel;
    end

    // estimate never exceeds the quotient and is at most one below it
    always_comb
    begin
        prod = (N_W + RECIP_W)'(n1_reg) * (N_W + RECIP_W)'(RECIP);
        v2_next    = v1_reg;
        n2_next    = n1_reg;
        q2_next    = prod[FRAC +: 8];
        cnt2_next  = cnt1_reg;
        dest2_next = dest1_reg;
    end

    always_comb
    begin
        rem = n2_reg - N_W'(q2_reg) * D2_C;
        v3_next    = v2_reg;
        a3_next    = (rem >= D2_C) ? q2_reg + 8'd1 : q2_reg;
        cnt3_next  = cnt2_reg;
        dest3_next = dest2_reg;
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            x4_next[c] = 16'(dest3_reg[8*c +: 8]) * 16'(CHAN_MAX - a3_reg)
                       + 16'(source_color[8*c +: 8]) * 16'(a3_reg);
        end
        v4_next     = v3_reg;
        cnt4_next   = cnt3_reg;
        alpha4_next = dest3_reg[31:24];
    end

    // floor(x / 255) as (x + (x >> 8) + 1) >> 8, exact for x up to 255 * 255
    always_comb
    begin
        quo = '0;
        for (int c = 0; c < 3; c++)
        begin
            quo = 17'(x4_reg[c]) + 17'(x4_reg[c] >> 8) + 17'd1;
            chan[c] = quo[15:8];
        end
        done_next                = v4_reg;
        res_next.new_pixel       = {alpha4_reg, chan[2], chan[1], chan[0]};
        res_next.write_enable    = (cnt4_reg != '0);
        res_next.coverage_count  = cnt4_reg[4:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= v1_next;
            v2_reg   <= v2_next;
            v3_reg   <= v3_next;
            v4_reg   <= v4_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n1_reg     <= n1_next;
        cnt1_reg   <= cnt1_next;
        dest1_reg  <= dest1_next;
        n2_reg     <= n2_next;
        q2_reg     <= q2_next;
        cnt2_reg   <= cnt2_next;
        dest2_reg  <= dest2_next;
        a3_reg     <= a3_next;
        cnt3_reg   <= cnt3_next;
        dest3_reg  <= dest3_next;
        x4_reg     <= x4_next;
        cnt4_reg   <= cnt4_next;
        alpha4_reg <= alpha4_next;
        res_reg    <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

### hdl/antialiased_circle_pixel_blend.sv
// top level of the anti-aliased circle pixel blender: config registers and pipeline
// depends on acpb_pkg, acpb_coverage and acpb_blend
`default_nettype none

// shades one pixel of an anti-aliased filled circle per clock. a request (start high,
// busy is always low) carries the pixel coordinate and the current framebuffer value;
// after the last pipeline stage, done pulses for one cycle with the blended pixel,
// a write flag and the covered subsample count. of the pipeline stages, the first
// five test the subsample grid against the circle and count hits, and five more
// scale the source alpha by coverage and blend blue, green and red. a new request may
// follow every cycle and results come out in request order with no back-pressure, so
// the receiver must take each one as it appears. with no coverage the write flag is low
// and the pixel passes through unchanged. config registers are written through
// cfg_write / cfg_index / cfg_data and should only change while no request is in flight.
module antialiased_circle_pixel_blend #(
    parameter int SUBSAMPLE_RADIUS = 2
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire acpb_pkg::pixel_req_t req,
    output logic                      done,
    output acpb_pkg::pixel_res_t      result,
    input  wire logic                 cfg_write,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [31:0]          cfg_data
);
    import acpb_pkg::*;

    localparam int LATENCY = COV_STAGES + BLEND_STAGES;

    // configuration registers
    logic signed [13:0] center_x_reg, center_x_next;
    logic signed [13:0] center_y_reg, center_y_next;
    logic [11:0]        radius_reg, radius_next;
    logic [31:0]        source_color_reg, source_color_next;

    circle_cfg_t circle;
    cov_bus_t    cov;

    // the pipeline never stalls, so every request is taken
    assign busy = 1'b0;

    always_comb
    begin
        center_x_next     = center_x_reg;
        center_y_next     = center_y_reg;
        radius_next       = radius_reg;
        source_color_next = source_color_reg;
        if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CENTER_X:     center_x_next     = cfg_data[13:0];
                REG_CENTER_Y:     center_y_next     = cfg_data[13:0];
                REG_RADIUS:       radius_next       = cfg_data[11:0];
                REG_SOURCE_COLOR: source_color_next = cfg_data;
                default:          center_x_next     = center_x_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg     <= '0;
            center_y_reg     <= '0;
            radius_reg       <= '0;
            source_color_reg <= '0;
        end
        else
        begin
            center_x_reg     <= center_x_next;
            center_y_reg     <= center_y_next;
            radius_reg       <= radius_next;
            source_color_reg <= source_color_next;
        end
    end

    assign circle.center_x = center_x_reg;
    assign circle.center_y = center_y_reg;
    assign circle.radius   = radius_reg;

    // geometry and subsample count
    acpb_coverage #(
        .SUBSAMPLE_RADIUS (SUBSAMPLE_RADIUS)
    ) u_coverage (
        .clk    (clk),
        .rst_n  (rst_n),
        .valid  (start & ~busy),
        .req    (req),
        .circle (circle),
        .cov    (cov)
    );

    // alpha scaling, blend and output register
    acpb_blend #(
        .SUBSAMPLE_RADIUS (SUBSAMPLE_RADIUS)
    ) u_blend (
        .clk          (clk),
        .rst_n        (rst_n),
        .cov          (cov),
        .source_color (source_color_reg),
        .done         (done),
        .result       (result)
    );

`ifndef ASSERT_OFF
    // each request gives exactly one result after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done == $past(start & ~busy, LATENCY))
        else $error("result strobe does not match request timing");

    // a pixel that is not written carries no coverage
    a_nowrite_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.write_enable |-> result.coverage_count == '0)
        else $error("coverage reported on an unwritten pixel");

    // an uncovered pixel passes through unchanged
    a_passthrough: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.write_enable |-> result.new_pixel == $past(req.dest_pixel, LATENCY))
        else $error("uncovered pixel was modified");
`endif

endmodule

`default_nettype wire

### tb/tb_antialiased_circle_pixel_blend.sv
`timescale 1ns / 100ps
// self-checking testbench for the anti-aliased circle pixel blender
// depends on acpb_pkg and antialiased_circle_pixel_blend; predicts every pixel in-house

module tb_antialiased_circle_pixel_blend;

    import acpb_pkg::*;

    // subsample grid half-width, kept equal to the parameter handed to the dut
    localparam int SUB_R      = 2;
    localparam int GRID       = 2 * SUB_R + 1;
    localparam int PIPE_DEPTH = COV_STAGES + BLEND_STAGES;
    localparam int STALL_MAX  = 4000;
    localparam int PHASES     = 10;
    localparam int PER_PHASE  = 155;

    // tracks the circle registers, predicts each request's pixel and holds the
    // predictions until the matching result pulses out
    class shade_checker;
        longint      cen_x;
        longint      cen_y;
        longint      rad;
        logic [31:0] fill;
        pixel_res_t  awaited[$];
        int          errors;

        function new();
            cen_x  = 0;
            cen_y  = 0;
            rad    = 0;
            fill   = '0;
            errors = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [31:0] d);
            case (idx)
                REG_CENTER_X:     cen_x = longint'($signed(d[13:0]));
                REG_CENTER_Y:     cen_y = longint'($signed(d[13:0]));
                REG_RADIUS:       rad   = longint'(d[11:0]);
                REG_SOURCE_COLOR: fill  = d;
                default: ;
            endcase
        endfunction

        function logic [7:0] mix(int unsigned d, int unsigned s, int unsigned a);
            int unsigned v;
            v = (d * (255 - a) + s * a) / 255;
            return 8'(v);
        endfunction

        function pixel_res_t shade(pixel_req_t r);
            longint      bx;
            longint      by;
            longint      lim;
            longint      ix;
            longint      iy;
            int unsigned hits;
            int unsigned a;
            pixel_res_t  res;
            bx   = (longint'(r.pixel_x) - cen_x) * SUB_R;
            by   = (longint'(r.pixel_y) - cen_y) * SUB_R;
            lim  = (rad * SUB_R) * (rad * SUB_R);
            hits = 0;
            for (int ay = -SUB_R; ay <= SUB_R; ay++)
            begin
                for (int ax = -SUB_R; ax <= SUB_R; ax++)
                begin
                    ix = bx + ax;
                    iy = by + ay;
                    if (ix * ix + iy * iy <= lim)
                        hits++;
                end
            end
            if (hits == 0)
            begin
                res.new_pixel      = r.dest_pixel;
                res.write_enable   = 1'b0;
                res.coverage_count = '0;
            end
            else
            begin
                a = hits * fill[31:24] / (GRID * GRID);
                res.new_pixel = {r.dest_pixel[31:24],
                                 mix(r.dest_pixel[23:16], fill[23:16], a),
                                 mix(r.dest_pixel[15:8],  fill[15:8],  a),
                                 mix(r.dest_pixel[7:0],   fill[7:0],   a)};
                res.write_enable   = 1'b1;
                res.coverage_count = 5'(hits);
            end
            return res;
        endfunction

        function void note_request(pixel_req_t r);
            awaited.push_back(shade(r));
        endfunction

        function void check_result(pixel_res_t got);
            pixel_res_t exp;
            if (awaited.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: pixel %h we %b cov %0d",
                             got.new_pixel, got.write_enable, got.coverage_count);
                return;
            end
            exp = awaited.pop_front();
            if (got.new_pixel !== exp.new_pixel || got.write_enable !== exp.write_enable
                || got.coverage_count !== exp.coverage_count)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: pixel %h/%h we %b/%b cov %0d/%0d (expected/actual)",
                             exp.new_pixel, got.new_pixel, exp.write_enable,
                             got.write_enable, exp.coverage_count, got.coverage_count);
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        start     = 1'b0;
    logic        busy;
    pixel_req_t  req       = '0;
    logic        done;
    pixel_res_t  result;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    shade_checker board = new();
    int           burst_left = 0;
    int           idle_cycles = 0;

    always #6 clk = ~clk;

    antialiased_circle_pixel_blend #(
        .SUBSAMPLE_RADIUS (SUB_R)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // monitor: everything sampled at the rising edge, so the values seen are the
    // ones that were settled before it. results are checked before the request of
    // the same edge is noted; the pipeline is far too deep for the two to meet
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                board.check_result(result);
            if (start && !busy)
                board.note_request(req);
            // watchdog on handshake activity, not on total run length
            if (done || (start && !busy))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_MAX)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // one register write per edge; cfg_write is left high for back-to-back writes
    // and the caller lowers it. the shadow copy is updated once the edge has taken it
    task automatic write_reg(cfg_reg_t idx, logic [31:0] d);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        board.set_reg(idx, d);
    endtask

    // loads the whole circle; unused upper bits of the narrow registers get junk
    // so that the truncation to register width is exercised too
    task automatic program_circle(int cx, int cy, int r, logic [31:0] color);
        write_reg(REG_CENTER_X, ($urandom() & 32'hFFFF_C000) | (cx & 32'h3FFF));
        write_reg(REG_CENTER_Y, ($urandom() & 32'hFFFF_C000) | (cy & 32'h3FFF));
        write_reg(REG_RADIUS,   ($urandom() & 32'hFFFF_F000) | (r & 32'hFFF));
        write_reg(REG_SOURCE_COLOR, color);
        cfg_write <= 1'b0;
    endtask

    // drain the pipeline before touching the registers: every request gives a
    // result, so an empty queue plus the pipeline depth means nothing in flight
    task automatic settle();
        start      <= 1'b0;
        burst_left  = 0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 2) @(posedge clk);
    endtask

    // issues one request and waits for it to be taken. requests come in bursts;
    // between bursts start drops for a random number of cycles. a zero gap keeps
    // start high so it is never lowered and raised within one step
    task automatic send(int x, int y, logic [31:0] d);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 8);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        start             <= 1'b1;
        req.pixel_x       <= 12'(x);
        req.pixel_y       <= 12'(y);
        req.dest_pixel    <= d;
        do
            @(posedge clk);
        while (busy);
        burst_left--;
    endtask

    initial
    begin
        int          cx;
        int          cy;
        int          r;
        int          span;
        int          px;
        int          py;
        logic [7:0]  alpha;
        logic [31:0] color;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset registers: zero radius at the origin, so only pixel (0,0) and its direct neighbours are hit
        send(0, 0, $urandom());
        send(1, 0, 32'hFFFF_FFFF);
        send(4095, 4095, 32'h0000_0000);
        send(0, 4095, $urandom());

        // zero radius away from the origin: centre pixel gets one subsample only
        settle();
        program_circle(100, 200, 0, 32'hFFA0_B0C0);
        send(100, 200, 32'h1234_5678);
        send(101, 200, $urandom());
        send(99, 199, $urandom());

        // small circle: full cover at the centre, partial cover on the rim, and a
        // pixel one beyond the radius that still catches the rim subsample
        settle();
        program_circle(2048, 2048, 3, 32'hFF00_FF80);
        send(2048, 2048, 32'h0000_0000);
        send(2051, 2048, 32'hFFFF_FFFF);
        send(2052, 2048, $urandom());
        send(2053, 2048, $urandom());
        send(2050, 2050, $urandom());

        // centre registers at their extremes, circle entirely off the canvas
        settle();
        program_circle(8191, -8192, 4095, 32'h00FF_FFFF);
        send(4095, 0, $urandom());
        send(0, 4095, $urandom());

        // zero source alpha: written pixels still carry the destination colour
        settle();
        program_circle(0, 0, 4095, 32'h00FF_FFFF);
        send(0, 0, $urandom());
        send(4095, 0, $urandom());
        send(4095, 4095, $urandom());

        // full alpha over a circle covering the whole canvas
        settle();
        program_circle(2047, 2047, 4095, 32'hFF00_00FF);
        send(0, 0, $urandom());
        send(4095, 4095, $urandom());

        // random phases, the first few pinned to register extremes
        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            case ($urandom_range(0, 5))
                0:       cx = -8192;
                1:       cx = 8191;
                default: cx = int'($urandom_range(0, 4607)) - 256;
            endcase
            cy = int'($urandom_range(0, 4607)) - 256;
            r  = int'($urandom_range(1, 40));
            if ($urandom_range(0, 4) == 0)
                r = $urandom_range(0, 4095);
            if (p == 0)
                r = 0;
            else if (p == 1)
                r = 4095;
            else if (p == 2)
                cx = -8192;
            else if (p == 3)
                cy = 8191;
            case ($urandom_range(0, 3))
                0:       alpha = 8'h00;
                1:       alpha = 8'hFF;
                default: alpha = 8'($urandom());
            endcase
            color = {alpha, 24'($urandom())};
            program_circle(cx, cy, r, color);

            // mostly pixels inside the circle's box so the rim is hit often,
            // the rest anywhere on the canvas
            span = r + 2;
            for (int n = 0; n < PER_PHASE; n++)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    px = cx + int'($urandom_range(0, 2 * span)) - span;
                    py = cy + int'($urandom_range(0, 2 * span)) - span;
                end
                else
                begin
                    px = -1;
                    py = -1;
                end
                if (px < 0 || px > 4095)
                    px = $urandom_range(0, 4095);
                if (py < 0 || py > 4095)
                    py = $urandom_range(0, 4095);
                send(px, py, $urandom());
            end
        end

        settle();
        if (board.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### sim.f
hdl/acpb_pkg.sv
hdl/acpb_coverage.sv
hdl/acpb_blend.sv
hdl/antialiased_circle_pixel_blend.sv
tb/tb_antialiased_circle_pixel_blend.sv
